// ----- rtl/text_console_writer_assert.svh -----
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, gated off while reset is high.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off while reset is high.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int TCW_COLUMNS = 80;
   localparam int TCW_ROWS    = 25;

   localparam logic [7:0]  RESET_ATTR  = 8'h0F;
   localparam logic [7:0]  CH_LF       = 8'd10;
   localparam logic [7:0]  CH_CR       = 8'd13;
   localparam logic [7:0]  CH_SPACE    = 8'h20;
   localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } tcw_cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_COPY,
      ST_FILL,
      ST_READ,
      ST_RESP
   } tcw_state_type;

   typedef struct packed {
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic        scrolled;
      logic [15:0] cell_value;
   } tcw_result_type;

endpackage

// ----- rtl/text_console_writer.sv -----
// Text console writer top level: attribute register, sequencer, store, response register.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

// Text-mode console: a COLUMNS x ROWS store of 16-bit cells (attribute high,
// character low) plus a cursor.
// Request channel (req_*): command 0 puts a character (LF, CR or printable,
// scrolling when the cursor runs past the last row), 1 clears the screen and
// homes the cursor, 2 reads one cell. Every request yields one response
// (rsp_*) with the cursor after the command, a scrolled flag and the cell read.
// csr_write_enable loads csr_write_data as the attribute for written cells.
// Sequence from the accepting edge to the edge that raises rsp_valid:
//   put without scroll, unused command: response load
//   read: registered store read, then response load
//   put with scroll: rows copied up by one, bottom row blanked, response load
//   clear: one cell per cycle, then the response load
// The sequencer is idle the cycle after it loads a response and takes no new
// request while busy. req_stall is low only when it is idle.
// After reset the store is blanked with attribute 0x0F, one cell per cycle,
// with req_stall high; csr writes still land.
// A stalled response sits in the output register; the next request is still
// accepted and finishes into a holding state until the register frees up.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
   parameter int ROWS = tcw_pkg::TCW_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_scrolled,
   output logic [15:0] rsp_cell_value,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   logic [7:0]        attr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tcw_result_type    rsp_ff;

   logic              seq_ready;
   logic              seq_done;
   logic              slot_free;
   logic              req_take;
   tcw_result_type    seq_result;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [15:0]       mem_rdata;

   logic              cursor_ok;
   logic              scroll_home;

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   assign req_stall = !seq_ready;
   assign req_take  = req_valid && seq_ready;
   // output register can load when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   tcw_seq #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .ADDR_W(ADDR_W)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_take(req_take),
      .req_command(req_command),
      .req_char_code(req_char_code),
      .req_cell_index(req_cell_index),
      .attr(attr_ff),
      .slot_free(slot_free),
      .ready(seq_ready),
      .done(seq_done),
      .result(seq_result),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_re(mem_re),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   tcw_store #(
      .DEPTH(CELLS),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock(clock),
      .write_enable(mem_we),
      .write_addr(mem_waddr),
      .write_data(mem_wdata),
      .read_enable(mem_re),
      .read_addr(mem_raddr),
      .read_data(mem_rdata)
   );

   // response register
   always_comb begin
      if (seq_done && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done && slot_free) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_column = rsp_ff.cursor_column;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_scrolled      = rsp_ff.scrolled;
   assign rsp_cell_value    = rsp_ff.cell_value;

   assign cursor_ok   = (32'(rsp_cursor_column) < COLUMNS) && (32'(rsp_cursor_row) < ROWS);
   assign scroll_home = (rsp_cursor_column == 7'd0) && (32'(rsp_cursor_row) == ROWS - 1);

   // a request that is taken keeps the sequencer busy the next cycle
   `TCW_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, req_stall, "stall low after take")
   // reported cursor always lies on the screen
   `TCW_ASSERT_NOW(a_cursor_on_screen, clock, reset, rsp_valid, cursor_ok, "cursor off screen")
   // a scroll leaves the cursor at the start of the bottom row
   `TCW_ASSERT_NOW(a_scroll_home, clock, reset, rsp_valid && rsp_scrolled, scroll_home, "bad scroll")

endmodule

// ----- rtl/tcw_store.sv -----
// Character cell frame store: one write port, one registered read port.
`timescale 1ns / 1ps

module tcw_store #(
   parameter int DEPTH = tcw_pkg::TCW_COLUMNS * tcw_pkg::TCW_ROWS,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [15:0]       write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [15:0]       read_data
);
   import tcw_pkg::*;

   logic [15:0] mem [DEPTH];
   logic [15:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/tcw_seq.sv -----
// Command sequencer: cursor, store sweeps for clear/scroll/init, cell reads.
`timescale 1ns / 1ps

module tcw_seq #(
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
   parameter int ROWS = tcw_pkg::TCW_ROWS,
   parameter int ADDR_W = $clog2(COLUMNS * ROWS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_take,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_char_code,
   input  logic [10:0]             req_cell_index,
   input  logic [7:0]              attr,
   input  logic                    slot_free,
   output logic                    ready,
   output logic                    done,
   output tcw_pkg::tcw_result_type result,
   output logic                    mem_we,
   output logic [ADDR_W-1:0]       mem_waddr,
   output logic [15:0]             mem_wdata,
   output logic                    mem_re,
   output logic [ADDR_W-1:0]       mem_raddr,
   input  logic [15:0]             mem_rdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
   localparam logic [4:0]        LAST_ROW  = 5'(ROWS - 1);

   tcw_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [6:0]        col_ff, col_in;
   logic [4:0]        row_ff, row_in;
   logic              scr_ff, scr_in;
   logic [15:0]       val_ff, val_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              pend_valid_ff, pend_valid_in;

   logic [15:0]       blank;
   logic [7:0]        col_inc;
   logic [5:0]        row_inc;
   logic [ADDR_W-1:0] cursor_addr;
   logic              idx_in_range;

   assign blank        = {attr, CH_SPACE};
   assign col_inc      = {1'b0, col_ff} + 8'd1;
   assign row_inc      = {1'b0, row_ff} + 6'd1;
   assign cursor_addr  = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign idx_in_range = 32'(req_cell_index) < CELLS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scr_ff       <= scr_in;
      val_ff       <= val_in;
      pend_addr_ff <= pend_addr_in;
   end

   always_comb begin
      logic [6:0] new_col;
      logic [5:0] new_row;

      new_col       = col_ff;
      new_row       = {1'b0, row_ff};
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      scr_in        = scr_ff;
      val_in        = val_ff;
      pend_addr_in  = pend_addr_ff;
      pend_valid_in = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff;
      mem_wdata     = blank;
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(req_cell_index);
      ready         = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            // power-up blanking uses the reset attribute, not the live register
            mem_we    = 1'b1;
            mem_wdata = RESET_BLANK;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            ready = 1'b1;
            if (req_take) begin
               scr_in = 1'b0;
               val_in = '0;
               unique case (tcw_cmd_type'(req_command))
                  CMD_PUT: begin
                     if (req_char_code == CH_LF) begin
                        new_col = '0;
                        new_row = row_inc;
                     end else if (req_char_code == CH_CR) begin
                        new_col = '0;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_addr;
                        mem_wdata = {attr, req_char_code};
                        if (32'(col_inc) >= COLUMNS) begin
                           new_col = '0;
                           new_row = row_inc;
                        end else begin
                           new_col = col_inc[6:0];
                        end
                     end
                     col_in = new_col;
                     if (32'(new_row) >= ROWS) begin
                        row_in   = LAST_ROW;
                        scr_in   = 1'b1;
                        cnt_in   = '0;
                        state_in = ST_COPY;
                     end else begin
                        row_in   = new_row[4:0];
                        state_in = ST_RESP;
                     end
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
                  CMD_READ: begin
                     if (idx_in_range) begin
                        mem_re   = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_COPY: begin
            // read one row ahead, write it back in the next cycle
            if (pend_valid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = mem_rdata;
            end
            if (cnt_ff != COPY_END) begin
               mem_re        = 1'b1;
               mem_raddr     = ADDR_W'(32'(cnt_ff) + COLUMNS);
               pend_addr_in  = cnt_ff;
               pend_valid_in = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            mem_we = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_READ: begin
            val_in   = mem_rdata;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            done = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.cursor_column = col_ff;
   assign result.cursor_row    = row_ff;
   assign result.scrolled      = scr_ff;
   assign result.cell_value    = val_ff;

endmodule
